/* src/assert_macros.svh */
// Assertion macros shared by the sky region classifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset
`define SRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included
`define SRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SRC_ASSERT(lbl, prop, msg)
`define SRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/src_pkg.sv */
// Shared constants and helpers for the sky region classifier
`default_nettype none
package src_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 15;
    localparam int Z_W            = 34;   // CORDIC angle accumulator, 2^32 per turn plus headroom

    // Q30 constants
    localparam longint Q30_COS_EPS     = 64'sd985042600;
    localparam longint Q30_SIN_EPS     = 64'sd427331948;
    localparam longint Q30_GX          = 64'sd931649273;
    localparam longint Q30_GY          = 64'sd212682915;
    localparam longint Q30_GZ          = 64'sd489609092;
    localparam longint Q30_CORDIC_GAIN = 64'sd652032874;

    // Outer survey latitude limit: 24*|lat| < 5 * 2^ANGLE_BITS (75 degrees)
    localparam int OUTER_LAT_MUL = 24;
    localparam int OUTER_LAT_NUM = 5;

    localparam logic [1:0] REGION_NONE  = 2'd0;
    localparam logic [1:0] REGION_INNER = 2'd1;
    localparam logic [1:0] REGION_OUTER = 2'd2;
    localparam logic [1:0] REGION_RSVD  = 2'd3;

    localparam logic [1:0] CFG_ECL_CUT    = 2'd0;
    localparam logic [1:0] CFG_ECL_MARGIN = 2'd1;
    localparam logic [1:0] CFG_GAL_CUT    = 2'd2;
    localparam logic [1:0] CFG_GAL_MARGIN = 2'd3;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    function automatic logic signed [Z_W-1:0] atan_z(input int idx);
        return $signed({{(Z_W-32){1'b0}}, ATAN_TAB[idx[4:0]]});
    endfunction

endpackage
`default_nettype wire

/* src/src_sincos.sv */
// Two-lane pipelined rotation CORDIC: sine and cosine of longitude and latitude
`default_nettype none
module src_sincos #(
    parameter int FRAC_BITS = src_pkg::FRAC_BITS_DEF,
    parameter int TAG_W     = src_pkg::ANGLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [31:0]            lon_ph,
    input  logic [31:0]            lat_ph,
    input  logic [TAG_W-1:0]       in_tag,
    output logic                   out_valid,
    output logic signed [FRAC_BITS+2:0] cos_lon,
    output logic signed [FRAC_BITS+2:0] sin_lon,
    output logic signed [FRAC_BITS+2:0] cos_lat,
    output logic signed [FRAC_BITS+2:0] sin_lat,
    output logic [TAG_W-1:0]       out_tag
);
    localparam int N  = FRAC_BITS + 1;
    localparam int VW = FRAC_BITS + 3;
    localparam int ZW = src_pkg::Z_W;
    localparam longint X0_L = ((src_pkg::Q30_CORDIC_GAIN * 2) +
                               (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
    localparam logic signed [VW-1:0] X0 = VW'(X0_L);

    logic signed [VW-1:0] x_reg   [N+1][2];
    logic signed [VW-1:0] y_reg   [N+1][2];
    logic signed [ZW-1:0] z_reg   [N+1][2];
    logic                 neg_reg [N+1][2];
    logic [TAG_W-1:0]     tag_reg [N+1];
    logic [N+1:0]         vld_reg;
    logic [31:0]          ph_in   [2];

    always_comb begin
        ph_in[0] = lon_ph;
        ph_in[1] = lat_ph;
    end

    // Fold quadrants 1 and 2 by half a turn; the folded phase sign is bit 30
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                neg_reg[0][l] <= ph_in[l][31] ^ ph_in[l][30];
                z_reg[0][l]   <= $signed({{(ZW-31){ph_in[l][30]}}, ph_in[l][30:0]});
                x_reg[0][l]   <= X0;
                y_reg[0][l]   <= '0;
            end
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_K = src_pkg::atan_z(k - 1);
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    if (!z_reg[k-1][l][ZW-1]) begin
                        x_reg[k][l] <= x_reg[k-1][l] - (y_reg[k-1][l] >>> (k - 1));
                        y_reg[k][l] <= y_reg[k-1][l] + (x_reg[k-1][l] >>> (k - 1));
                        z_reg[k][l] <= z_reg[k-1][l] - ATAN_K;
                    end else begin
                        x_reg[k][l] <= x_reg[k-1][l] + (y_reg[k-1][l] >>> (k - 1));
                        y_reg[k][l] <= y_reg[k-1][l] - (x_reg[k-1][l] >>> (k - 1));
                        z_reg[k][l] <= z_reg[k-1][l] + ATAN_K;
                    end
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Undo the fold
    always_ff @(posedge aclk) begin
        if (adv) begin
            cos_lon <= neg_reg[N][0] ? -x_reg[N][0] : x_reg[N][0];
            sin_lon <= neg_reg[N][0] ? -y_reg[N][0] : y_reg[N][0];
            cos_lat <= neg_reg[N][1] ? -x_reg[N][1] : x_reg[N][1];
            sin_lat <= neg_reg[N][1] ? -y_reg[N][1] : y_reg[N][1];
            out_tag <= tag_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N:0], in_valid};
        end
    end

    assign out_valid = vld_reg[N+1];
endmodule
`default_nettype wire

/* src/src_proj.sv */
// Pipelined unit vector, obliquity rotation and galactic sine
`default_nettype none
module src_proj #(
    parameter int FRAC_BITS = src_pkg::FRAC_BITS_DEF,
    parameter int TAG_W     = src_pkg::ANGLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic signed [FRAC_BITS+2:0] cos_lon,
    input  logic signed [FRAC_BITS+2:0] sin_lon,
    input  logic signed [FRAC_BITS+2:0] cos_lat,
    input  logic signed [FRAC_BITS+2:0] sin_lat,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] sin_gal,
    output logic [2*FRAC_BITS:0]        radicand,
    output logic [TAG_W-1:0]            out_tag
);
    localparam int VW = FRAC_BITS + 3;
    localparam int PW = 2 * VW;
    localparam int MW = VW + 32;
    localparam int SW = FRAC_BITS + 2;
    localparam int RW = 2 * FRAC_BITS + 1;
    localparam int NST = 8;

    localparam logic signed [31:0] C_COS = 32'(src_pkg::Q30_COS_EPS);
    localparam logic signed [31:0] C_SIN = 32'(src_pkg::Q30_SIN_EPS);
    localparam logic signed [31:0] C_GX  = 32'(src_pkg::Q30_GX);
    localparam logic signed [31:0] C_GY  = 32'(src_pkg::Q30_GY);
    localparam logic signed [31:0] C_GZ  = 32'(src_pkg::Q30_GZ);

    localparam logic signed [PW-1:0]   RND_F   = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [MW:0]     RND_30  = (MW+1)'(1) <<< 29;
    localparam logic signed [MW+1:0]   RND_30S = (MW+2)'(1) <<< 29;
    localparam logic signed [SW-1:0]   ONE     = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0]   NEG_ONE = -ONE;
    localparam logic [2*SW-1:0]        ONE_SQ  = (2*SW)'(1) << (2 * FRAC_BITS);

    // stage 1
    logic signed [PW-1:0] pcl_reg, psl_reg;
    logic signed [VW-1:0] sb1_reg;
    // stage 2
    logic signed [VW-1:0] tx2_reg, ty2_reg, tz2_reg;
    // stage 3
    logic signed [MW-1:0] myc_reg, mzs_reg, mys_reg, mzc_reg;
    logic signed [VW-1:0] tx3_reg;
    // stage 4
    logic signed [VW-1:0] tx4_reg, ey4_reg, ez4_reg;
    // stage 5
    logic signed [MW-1:0] gx_reg, gy_reg, gz_reg;
    // stage 6, 7
    logic signed [SW-1:0]   s6_reg, s7_reg;
    logic signed [2*SW-1:0] ss7_reg;
    logic [TAG_W-1:0]       tag_reg [NST];
    logic [NST-1:0]         vld_reg;

    logic signed [PW-1:0]   tx_rnd, ty_rnd;
    logic signed [MW:0]     ey_sum, ez_sum;
    logic signed [MW+1:0]   g_sum;
    logic signed [MW+1:0]   g_shf;
    logic signed [SW-1:0]   s_next;
    logic [2*SW-1:0]        rad_full;

    always_comb begin
        tx_rnd = (pcl_reg + RND_F) >>> FRAC_BITS;
        ty_rnd = (psl_reg + RND_F) >>> FRAC_BITS;
        ey_sum = ((MW+1)'(myc_reg) - (MW+1)'(mzs_reg) + RND_30) >>> 30;
        ez_sum = ((MW+1)'(mys_reg) + (MW+1)'(mzc_reg) + RND_30) >>> 30;
        g_sum  = (MW+2)'(gz_reg) - (MW+2)'(gx_reg) - (MW+2)'(gy_reg) + RND_30S;
        g_shf  = g_sum >>> 30;
        if (g_shf > (MW+2)'(ONE)) begin
            s_next = ONE;
        end else if (g_shf < (MW+2)'(NEG_ONE)) begin
            s_next = NEG_ONE;
        end else begin
            s_next = g_shf[SW-1:0];
        end
        rad_full = ONE_SQ - $unsigned(ss7_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pcl_reg  <= cos_lat * cos_lon;
            psl_reg  <= cos_lat * sin_lon;
            sb1_reg  <= sin_lat;
            tx2_reg  <= tx_rnd[VW-1:0];
            ty2_reg  <= ty_rnd[VW-1:0];
            tz2_reg  <= sb1_reg;
            myc_reg  <= ty2_reg * C_COS;
            mzs_reg  <= tz2_reg * C_SIN;
            mys_reg  <= ty2_reg * C_SIN;
            mzc_reg  <= tz2_reg * C_COS;
            tx3_reg  <= tx2_reg;
            ey4_reg  <= ey_sum[VW-1:0];
            ez4_reg  <= ez_sum[VW-1:0];
            tx4_reg  <= tx3_reg;
            gx_reg   <= tx4_reg * C_GX;
            gy_reg   <= ey4_reg * C_GY;
            gz_reg   <= ez4_reg * C_GZ;
            s6_reg   <= s_next;
            ss7_reg  <= s6_reg * s6_reg;
            s7_reg   <= s6_reg;
            sin_gal  <= s7_reg;
            radicand <= rad_full[RW-1:0];
            tag_reg[0] <= in_tag;
            for (int i = 1; i < NST; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_tag   = tag_reg[NST-1];
endmodule
`default_nettype wire

/* src/src_asin.sv */
// Pipelined integer square root and vectoring CORDIC: arcsine to binary angle
`default_nettype none
module src_asin #(
    parameter int ANGLE_BITS = src_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = src_pkg::FRAC_BITS_DEF,
    parameter int TAG_W      = src_pkg::ANGLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic signed [FRAC_BITS+1:0]  sin_gal,
    input  logic [2*FRAC_BITS:0]         radicand,
    input  logic [TAG_W-1:0]             in_tag,
    output logic                         out_valid,
    output logic signed [ANGLE_BITS-1:0] gal_lat,
    output logic [TAG_W-1:0]             out_tag
);
    localparam int N   = FRAC_BITS + 1;
    localparam int VW  = FRAC_BITS + 3;
    localparam int SW  = FRAC_BITS + 2;
    localparam int RSW = 2 * FRAC_BITS + 3;
    localparam int ZW  = src_pkg::Z_W;
    localparam int NQ  = FRAC_BITS + 2;          // root stages incl. capture
    localparam int L   = NQ + N + 2;             // total stages incl. output
    localparam int SHF = 32 - ANGLE_BITS;
    localparam logic signed [ZW-1:0] RND_Z   = ZW'(1) <<< (SHF - 1);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [ZW-1:0] NEG_QTR = -QUARTER;

    logic [RSW-1:0]       n_reg  [NQ];
    logic [RSW-1:0]       r_reg  [NQ];
    logic signed [SW-1:0] sq_reg [NQ];
    logic signed [VW-1:0] vx_reg [N+1];
    logic signed [VW-1:0] vy_reg [N+1];
    logic signed [ZW-1:0] vz_reg [N+1];
    logic [TAG_W-1:0]     tag_reg [L];
    logic [L-1:0]         vld_reg;
    logic signed [ZW-1:0] z_shf;
    logic signed [ZW-1:0] gal_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg[0]  <= RSW'(radicand);
            r_reg[0]  <= '0;
            sq_reg[0] <= sin_gal;
        end
    end

    // One bit of the root per stage, largest power of four first
    for (genvar j = 1; j < NQ; j++) begin : g_root
        localparam logic [RSW-1:0] BIT = RSW'(1) << (2 * (FRAC_BITS - (j - 1)));
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (n_reg[j-1] >= r_reg[j-1] + BIT) begin
                    n_reg[j] <= n_reg[j-1] - (r_reg[j-1] + BIT);
                    r_reg[j] <= (r_reg[j-1] >> 1) + BIT;
                end else begin
                    n_reg[j] <= n_reg[j-1];
                    r_reg[j] <= r_reg[j-1] >> 1;
                end
                sq_reg[j] <= sq_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx_reg[0] <= $signed(r_reg[NQ-1][VW-1:0]);
            vy_reg[0] <= VW'(sq_reg[NQ-1]);
            vz_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_vec
        localparam logic signed [ZW-1:0] ATAN_K = src_pkg::atan_z(k - 1);
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!vy_reg[k-1][VW-1]) begin
                    vx_reg[k] <= vx_reg[k-1] + (vy_reg[k-1] >>> (k - 1));
                    vy_reg[k] <= vy_reg[k-1] - (vx_reg[k-1] >>> (k - 1));
                    vz_reg[k] <= vz_reg[k-1] + ATAN_K;
                end else begin
                    vx_reg[k] <= vx_reg[k-1] - (vy_reg[k-1] >>> (k - 1));
                    vy_reg[k] <= vy_reg[k-1] + (vx_reg[k-1] >>> (k - 1));
                    vz_reg[k] <= vz_reg[k-1] - ATAN_K;
                end
            end
        end
    end

    always_comb begin
        z_shf = (vz_reg[N] + RND_Z) >>> SHF;
        if (z_shf > QUARTER) begin
            gal_next = QUARTER;
        end else if (z_shf < NEG_QTR) begin
            gal_next = NEG_QTR;
        end else begin
            gal_next = z_shf;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gal_lat    <= gal_next[ANGLE_BITS-1:0];
            tag_reg[0] <= in_tag;
            for (int i = 1; i < L; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[L-1];
    assign out_tag   = tag_reg[L-1];
endmodule
`default_nettype wire

/* src/sky_region_classifier.sv */
// Top level of the sky region classifier: ecliptic point to galactic latitude and region
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_ecl_lon, s_ecl_lat
//  m_        out        m_valid / m_ready    m_region, m_gal_lat
//  cfg_      in         cfg_wr_en            cfg_addr, cfg_wdata (write only)
//
// One request per cycle sustained while the output is not stalled. The pipeline
// runs the sine/cosine CORDIC, the rotation products, the square root, the
// arcsine CORDIC and the region decision, in that order, as one shift chain: it
// advances whenever the output register is empty or being taken, so s_ready
// drops only while a finished result waits and the output is stalled.
// Synchronous active-low reset clears all valid bits and the four registers;
// no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module sky_region_classifier #(
    parameter int ANGLE_BITS = src_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = src_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input requests
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ANGLE_BITS-1:0]        s_ecl_lon,
    input  logic signed [ANGLE_BITS-1:0] s_ecl_lat,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_region,
    output logic signed [ANGLE_BITS-1:0] m_gal_lat,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_addr,
    input  logic [ANGLE_BITS-2:0]        cfg_wdata
);
    localparam int A  = ANGLE_BITS;
    localparam int CW = ANGLE_BITS - 1;
    localparam int VW = FRAC_BITS + 3;
    localparam logic [A+5:0] OUTER_LIM =
        (A+6)'(src_pkg::OUTER_LAT_NUM) << A;
    localparam logic [5:0]   LAT_MUL   = 6'(src_pkg::OUTER_LAT_MUL);
    localparam logic signed [A-1:0] QUARTER = A'(1) <<< (A - 2);
    localparam logic signed [A-1:0] NEG_QTR = -QUARTER;

    // whole pipeline shifts together
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // configuration registers
    logic [CW-1:0] ecl_cut_reg, ecl_margin_reg, gal_cut_reg, gal_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecl_cut_reg    <= '0;
            ecl_margin_reg <= '0;
            gal_cut_reg    <= '0;
            gal_margin_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                src_pkg::CFG_ECL_CUT:    ecl_cut_reg    <= cfg_wdata;
                src_pkg::CFG_ECL_MARGIN: ecl_margin_reg <= cfg_wdata;
                src_pkg::CFG_GAL_CUT:    gal_cut_reg    <= cfg_wdata;
                src_pkg::CFG_GAL_MARGIN: gal_margin_reg <= cfg_wdata;
            endcase
        end
    end

    // angles to 32-bit phase; the raw latitude rides along as a tag
    logic [31:0] lon_ph, lat_ph;
    assign lon_ph = {s_ecl_lon, {(32-A){1'b0}}};
    assign lat_ph = {s_ecl_lat, {(32-A){1'b0}}};

    logic                 sc_valid;
    logic signed [VW-1:0] cos_lon, sin_lon, cos_lat, sin_lat;
    logic [A-1:0]         sc_tag;

    src_sincos #(.FRAC_BITS(FRAC_BITS), .TAG_W(A)) u_sincos (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(s_valid && s_ready), .lon_ph(lon_ph), .lat_ph(lat_ph),
        .in_tag(s_ecl_lat),
        .out_valid(sc_valid), .cos_lon(cos_lon), .sin_lon(sin_lon),
        .cos_lat(cos_lat), .sin_lat(sin_lat), .out_tag(sc_tag)
    );

    logic                          pj_valid;
    logic signed [FRAC_BITS+1:0]   sin_gal;
    logic [2*FRAC_BITS:0]          radicand;
    logic [A-1:0]                  pj_tag;

    src_proj #(.FRAC_BITS(FRAC_BITS), .TAG_W(A)) u_proj (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(sc_valid), .cos_lon(cos_lon), .sin_lon(sin_lon),
        .cos_lat(cos_lat), .sin_lat(sin_lat), .in_tag(sc_tag),
        .out_valid(pj_valid), .sin_gal(sin_gal), .radicand(radicand),
        .out_tag(pj_tag)
    );

    logic                 as_valid;
    logic signed [A-1:0]  gal_lat;
    logic [A-1:0]         as_tag;

    src_asin #(.ANGLE_BITS(A), .FRAC_BITS(FRAC_BITS), .TAG_W(A)) u_asin (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(pj_valid), .sin_gal(sin_gal), .radicand(radicand),
        .in_tag(pj_tag),
        .out_valid(as_valid), .gal_lat(gal_lat), .out_tag(as_tag)
    );

    // region decision, inner band wins
    logic [A-1:0]   abs_lat;
    logic [A-1:0]   abs_gal;
    logic [A-1:0]   ecl_band, gal_band;
    logic [A+5:0]   lat_x24;
    logic           inner, outer;
    logic [1:0]     region_next;

    always_comb begin
        abs_lat  = as_tag[A-1] ? A'(-$signed(as_tag)) : as_tag;
        abs_gal  = gal_lat[A-1] ? A'(-gal_lat) : A'(gal_lat);
        ecl_band = A'(ecl_cut_reg) + A'(ecl_margin_reg);
        gal_band = A'(gal_cut_reg) + A'(gal_margin_reg);
        lat_x24  = (A+6)'(abs_lat) * (A+6)'(LAT_MUL);
        inner    = (abs_lat < ecl_band) && (abs_gal < gal_band);
        outer    = (abs_lat > A'(ecl_cut_reg)) && (lat_x24 < OUTER_LIM) &&
                   (abs_gal > A'(gal_cut_reg));
        priority if (inner) begin
            region_next = src_pkg::REGION_INNER;
        end else if (outer) begin
            region_next = src_pkg::REGION_OUTER;
        end else begin
            region_next = src_pkg::REGION_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_region  <= region_next;
            m_gal_lat <= gal_lat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= as_valid;
        end
    end

    `SRC_ASSERT(a_region_code, m_valid |-> (m_region != src_pkg::REGION_RSVD), "reserved region code")
    `SRC_ASSERT(a_gal_range, m_valid |-> ((m_gal_lat <= QUARTER) && (m_gal_lat >= NEG_QTR)), "gal_lat out of range")
    `SRC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")
    `SRC_ASSERT(a_no_accept_stalled, (m_valid && !m_ready) |-> !s_ready, "request taken while stalled")
endmodule
`default_nettype wire

/* test/tb_sky_region_classifier.sv */
// Self-checking testbench for the sky region classifier: predicts latitude and region per request
`default_nettype none
module tb_sky_region_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB = src_pkg::ANGLE_BITS_DEF;
    localparam int FB = src_pkg::FRAC_BITS_DEF;
    localparam int ITERS = FB + 1;
    localparam int LATENCY = 3 * FB + 17;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [AB-1:0]        lon;
        logic signed [AB-1:0] lat;
    } sky_point_t;

    typedef struct packed {
        logic [1:0]           region;
        logic signed [AB-1:0] gal;
    } region_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [AB-1:0] s_ecl_lon = '0;
    logic signed [AB-1:0] s_ecl_lat = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_region;
    logic signed [AB-1:0] m_gal_lat;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [AB-2:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    sky_region_classifier DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_ecl_lon(s_ecl_lon), .s_ecl_lat(s_ecl_lat),
        .m_valid(m_valid), .m_ready(m_ready), .m_region(m_region), .m_gal_lat(m_gal_lat),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Local copy of the four bounds, updated with every register write
    longint bound_ecl_cut, bound_ecl_margin, bound_gal_cut, bound_gal_margin;

    sky_point_t pending_points[$];
    region_result_t expected_results[$];
    int mismatches = 0;
    int checked = 0;
    int inner_seen = 0, outer_seen = 0, none_seen = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    // Floor shift that is exact for negative values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint atan_step(int i);
        return longint'(src_pkg::ATAN_TAB[i]);
    endfunction

    // Rotation-mode CORDIC for sine and cosine of a 32-bit phase
    task automatic phase_sincos(input logic [31:0] phase, output longint c, output longint s);
        logic [1:0] quad;
        bit flip;
        longint z, x, y, nx, ny;
        quad = phase[31:30];
        flip = (quad == 2'd1) || (quad == 2'd2);
        if (flip) phase = phase - 32'h8000_0000;
        z = longint'($signed(phase));
        x = round_shift(src_pkg::Q30_CORDIC_GAIN << 1, 31 - FB);
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= atan_step(i);
            end else begin
                nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += atan_step(i);
            end
            x = nx; y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint floor_sqrt(longint n);
        longint res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Full transform of one sky point to galactic latitude plus region decision
    task automatic classify_point(input sky_point_t p, output region_result_t r);
        longint lat, cl, sl, cb, sb, tx, ty, tz, ey, ez, sn, x, y, z, nx, ny, gal;
        longint one, quarter, abs_lat, abs_gal;
        logic [31:0] lon_ph, lat_ph;
        bit inner, outer;
        one = longint'(1) << FB;
        quarter = longint'(1) << (AB - 2);
        lat = longint'(p.lat);
        lon_ph = {p.lon, {(32 - AB){1'b0}}};
        lat_ph = {p.lat, {(32 - AB){1'b0}}};
        phase_sincos(lon_ph, cl, sl);
        phase_sincos(lat_ph, cb, sb);
        tx = round_shift(cb * cl, FB);
        ty = round_shift(cb * sl, FB);
        tz = sb;
        ey = round_shift(ty * src_pkg::Q30_COS_EPS - tz * src_pkg::Q30_SIN_EPS, 30);
        ez = round_shift(ty * src_pkg::Q30_SIN_EPS + tz * src_pkg::Q30_COS_EPS, 30);
        sn = round_shift(-src_pkg::Q30_GX * tx - src_pkg::Q30_GY * ey +
                         src_pkg::Q30_GZ * ez, 30);
        // sine clamp to [-1, 1]
        if (sn > one) sn = one;
        if (sn < -one) sn = -one;
        x = floor_sqrt(one * one - sn * sn);
        y = sn;
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += atan_step(i);
            end else begin
                nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= atan_step(i);
            end
            x = nx; y = ny;
        end
        gal = round_shift(z, 32 - AB);
        if (gal > quarter) gal = quarter;
        if (gal < -quarter) gal = -quarter;
        // region tests use the raw latitude field, even beyond ninety degrees
        abs_lat = lat < 0 ? -lat : lat;
        abs_gal = gal < 0 ? -gal : gal;
        inner = (abs_lat < bound_ecl_cut + bound_ecl_margin) &&
                (abs_gal < bound_gal_cut + bound_gal_margin);
        outer = (abs_lat > bound_ecl_cut) &&
                (abs_lat * src_pkg::OUTER_LAT_MUL < (longint'(src_pkg::OUTER_LAT_NUM) << AB)) &&
                (abs_gal > bound_gal_cut);
        r.region = inner ? src_pkg::REGION_INNER :
                   (outer ? src_pkg::REGION_OUTER : src_pkg::REGION_NONE);
        r.gal = gal[AB-1:0];
    endtask

    // Driver: one request from the pending queue, random gap before each
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                region_result_t r;
                classify_point({s_ecl_lon, s_ecl_lat}, r);
                expected_results.push_back(r);
                void'(pending_points.pop_front());
                send_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                if (!(s_valid && !s_ready)) s_valid <= 1'b0;
            end else if (!(s_valid && !s_ready)) begin
                if (pending_points.size() > 0) begin
                    s_valid <= 1'b1;
                    s_ecl_lon <= pending_points[0].lon;
                    s_ecl_lat <= pending_points[0].lat;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation, random back-pressure
    int recv_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result region=%0d gal=%0d", m_region, m_gal_lat);
                end else begin
                    region_result_t e;
                    e = expected_results.pop_front();
                    checked++;
                    case (e.region)
                        src_pkg::REGION_INNER: inner_seen++;
                        src_pkg::REGION_OUTER: outer_seen++;
                        default: none_seen++;
                    endcase
                    if (e.region !== m_region || e.gal !== m_gal_lat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected region=%0d gal=%0d, got region=%0d gal=%0d",
                                     e.region, e.gal, m_region, m_gal_lat);
                    end
                end
                recv_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d results outstanding", expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_bound(input logic [1:0] idx, input logic [AB-2:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            src_pkg::CFG_ECL_CUT:    bound_ecl_cut = val;
            src_pkg::CFG_ECL_MARGIN: bound_ecl_margin = val;
            src_pkg::CFG_GAL_CUT:    bound_gal_cut = val;
            default:                 bound_gal_margin = val;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_bounds(input logic [AB-2:0] ec, em, gc, gm);
        write_bound(src_pkg::CFG_ECL_CUT, ec);
        write_bound(src_pkg::CFG_ECL_MARGIN, em);
        write_bound(src_pkg::CFG_GAL_CUT, gc);
        write_bound(src_pkg::CFG_GAL_MARGIN, gm);
    endtask

    // Wait for the pipeline to drain fully
    task automatic drain_all();
        while (pending_points.size() > 0 || expected_results.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic sky_point_t rand_point();
        sky_point_t p;
        p.lon = AB'($urandom);
        case ($urandom_range(0, 5))
            0: p.lat = AB'($urandom);                                        // any pattern
            1: p.lat = AB'($signed($urandom_range(0, 32768)) - 16384);       // full legal range
            default: p.lat = AB'($signed($urandom_range(0, 2 * 13000)) - 13000);
        endcase
        return p;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) pending_points.push_back(rand_point());
    endtask

    initial begin
        logic [AB-1:0] lons[8];
        logic signed [AB-1:0] lats[9];
        bound_ecl_cut = 0; bound_ecl_margin = 0; bound_gal_cut = 0; bound_gal_margin = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: poles, equator, quadrant edges, beyond-ninety latitudes, all-ones fields
        set_bounds(15'd3641, 15'd1820, 15'd1820, 15'd1820);
        lons = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF, 16'h7FFF, 16'h5555};
        lats = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd16383, 16'h7FFF, 16'h8000,
                 16'hFFFF, 16'sd13653, -16'sd13654};
        for (int i = 0; i < 24; i++)
            pending_points.push_back({lons[i % 8], lats[i % 9]});
        drain_all();

        // Extremes of the bounds, including all-ones register values
        set_bounds(15'd0, 15'd0, 15'd0, 15'd0);
        random_phase(60);
        drain_all();
        set_bounds(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        random_phase(40);
        drain_all();
        set_bounds(15'd16384, 15'd0, 15'd16384, 15'd0);
        random_phase(40);
        drain_all();

        // Random settings; sender holds off until all results arrive between phases
        for (int ph = 0; ph < 6; ph++) begin
            set_bounds((AB-1)'($urandom_range(0, 8000)), (AB-1)'($urandom_range(0, 4000)),
                       (AB-1)'($urandom_range(0, 8000)), (AB-1)'($urandom_range(0, 4000)));
            random_phase(60);
            drain_all();
        end

        $display("checked %0d results over 10 bound settings: %0d inner, %0d outer, %0d none",
                 checked, inner_seen, outer_seen, none_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
